// ===== hw/rtl/cbrm_pkg.sv =====
// shared codes, field widths and payload types for the bus-off recovery monitor
`timescale 1ns / 1ps

package cbrm_pkg;

    // operation selector carried on the input tuser
    localparam logic [1:0] OP_UPDATE      = 2'd0;
    localparam logic [1:0] OP_TRIGGER     = 2'd1;
    localparam logic [1:0] OP_CLEAR_STATS = 2'd2;

    // controller bus states
    localparam logic [1:0] BUS_ACTIVE  = 2'd0;
    localparam logic [1:0] BUS_WARNING = 2'd1;
    localparam logic [1:0] BUS_PASSIVE = 2'd2;
    localparam logic [1:0] BUS_OFF     = 2'd3;

    // register indexes, byte address is 4 * index
    localparam int unsigned REG_IDX_BITS = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_USE_FINE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_BASE_DELAY = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FINE_DELAY = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_STABLE_RUN = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_AUTO_ON    = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ATT_LIMIT  = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_CNT_PRES   = 3'd6;

    localparam int unsigned ADDR_BITS = REG_IDX_BITS + 2;

    localparam logic [7:0] ATTEMPT_MAX = 8'hff;

    localparam int unsigned IN_TDATA_BITS  = 88;
    localparam int unsigned OUT_TDATA_BITS = 160;

    // input payload, highest field first
    typedef struct packed {
        logic [31:0] fine_tick;
        logic [31:0] base_tick;
        logic [7:0]  rx_error_count;
        logic [7:0]  tx_error_count;
        logic [1:0]  bus_state;
    } t_in_item;

    // result payload, highest field first
    typedef struct packed {
        logic [31:0] bus_off_total_time;
        logic [31:0] passive_entries;
        logic [31:0] warning_entries;
        logic [31:0] bus_off_entries;
        logic [7:0]  peak_rx_errors;
        logic [7:0]  peak_tx_errors;
        logic        recovery_failed;
        logic [7:0]  attempt_count;
        logic        request_recovery;
        logic        state_changed;
        logic [1:0]  held_state;
        logic        status;
    } t_out_item;

endpackage

// ===== hw/rtl/can_bus_off_recovery_monitor_top.sv =====
// top level of the can bus-off recovery monitor: config port, item pipeline, state update
`timescale 1ns / 1ps

// an input transfer goes to the input register, its result to the result register
// throughput: one item per cycle unless the master side stalls, an input register feeds
//   one step of update logic writing monitor state and result register at the same edge
// backpressure on the master side stalls both registers, no item is dropped
// reset (synchronous, active low) clears config registers, monitor state and valids

module can_bus_off_recovery_monitor_top #(
    parameter int unsigned TICK_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bus_state[1:0], tx_error_count[9:2], rx_error_count[17:10],
    // base_tick[49:18], fine_tick[81:50], zero fill [87:82]
    input  logic [cbrm_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
    // op[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // master side
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[0], held_state[2:1], state_changed[3], request_recovery[4],
    // attempt_count[12:5], recovery_failed[13], peak_tx_errors[21:14],
    // peak_rx_errors[29:22], bus_off_entries[61:30], warning_entries[93:62],
    // passive_entries[125:94], bus_off_total_time[157:126], zero fill [159:158]
    output logic [cbrm_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
    // config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cbrm_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import cbrm_pkg::*;

    localparam int unsigned TW = TICK_BITS;

    // config registers
    logic        r_use_fine;
    logic [31:0] r_base_delay;
    logic [31:0] r_fine_delay;
    logic [31:0] r_stable_run;
    logic        r_auto_on;
    logic [7:0]  r_att_limit;
    logic        r_cnt_pres;

    logic                    w_cfg_wr;
    logic [REG_IDX_BITS-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_fine   <= 1'b0;
            r_base_delay <= '0;
            r_fine_delay <= '0;
            r_stable_run <= '0;
            r_auto_on    <= 1'b0;
            r_att_limit  <= '0;
            r_cnt_pres   <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_USE_FINE:   r_use_fine   <= pwdata[0];
                REG_BASE_DELAY: r_base_delay <= pwdata;
                REG_FINE_DELAY: r_fine_delay <= pwdata;
                REG_STABLE_RUN: r_stable_run <= pwdata;
                REG_AUTO_ON:    r_auto_on    <= pwdata[0];
                REG_ATT_LIMIT:  r_att_limit  <= pwdata[7:0];
                REG_CNT_PRES:   r_cnt_pres   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_USE_FINE:   prdata = {31'd0, r_use_fine};
            REG_BASE_DELAY: prdata = r_base_delay;
            REG_FINE_DELAY: prdata = r_fine_delay;
            REG_STABLE_RUN: prdata = r_stable_run;
            REG_AUTO_ON:    prdata = {31'd0, r_auto_on};
            REG_ATT_LIMIT:  prdata = {24'd0, r_att_limit};
            REG_CNT_PRES:   prdata = {31'd0, r_cnt_pres};
            default:        prdata = '0;
        endcase
    end

    // two-register pipeline: input register, then result register
    logic      r_in_vld;
    t_in_item  r_in;
    logic [1:0] r_in_op;
    logic      r_out_vld;
    t_out_item r_out;
    logic      w_out_free;
    logic      w_advance;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_advance     = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_BITS - $bits(t_out_item)){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_axis_tready) r_in_vld <= s_axis_tvalid;
            if (w_out_free)    r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in    <= t_in_item'(s_axis_tdata[$bits(t_in_item)-1:0]);
            r_in_op <= s_axis_tuser;
        end
    end

    // monitor state
    logic [1:0]    r_state;
    logic [7:0]    r_peak_tx;
    logic [7:0]    r_peak_rx;
    logic [31:0]   r_off_cnt;
    logic [31:0]   r_warn_cnt;
    logic [31:0]   r_pass_cnt;
    logic [31:0]   r_off_sum;
    logic [TW-1:0] r_off_entry;
    logic [TW-1:0] r_retry_tick;
    logic [TW-1:0] r_retry_fine;
    logic [TW-1:0] r_grace_start;
    logic [TW-1:0] r_last_rec;
    logic          r_grace;
    logic [7:0]    r_attempts;

    logic [1:0]    n_state;
    logic [7:0]    n_peak_tx;
    logic [7:0]    n_peak_rx;
    logic [31:0]   n_off_cnt;
    logic [31:0]   n_warn_cnt;
    logic [31:0]   n_pass_cnt;
    logic [31:0]   n_off_sum;
    logic [TW-1:0] n_off_entry;
    logic [TW-1:0] n_retry_tick;
    logic [TW-1:0] n_retry_fine;
    logic [TW-1:0] n_grace_start;
    logic [TW-1:0] n_last_rec;
    logic          n_grace;
    logic [7:0]    n_attempts;
    t_out_item     n_out;

    // ticks brought to the timebase width: truncated or zero-extended
    logic [63:0]   w_now64;
    logic [63:0]   w_fnow64;
    logic [TW-1:0] w_now;
    logic [TW-1:0] w_fnow;

    assign w_now64  = {32'd0, r_in.base_tick};
    assign w_fnow64 = {32'd0, r_in.fine_tick};
    assign w_now    = w_now64[TW-1:0];
    assign w_fnow   = w_fnow64[TW-1:0];

    logic [TW-1:0] w_el_entry;
    logic [TW-1:0] w_el_grace;
    logic [TW-1:0] w_el_retry;
    logic [TW-1:0] w_el_fine;
    logic [TW-1:0] w_el_rec;
    logic          w_due;

    always_comb begin
        n_state       = r_state;
        n_peak_tx     = r_peak_tx;
        n_peak_rx     = r_peak_rx;
        n_off_cnt     = r_off_cnt;
        n_warn_cnt    = r_warn_cnt;
        n_pass_cnt    = r_pass_cnt;
        n_off_sum     = r_off_sum;
        n_off_entry   = r_off_entry;
        n_retry_tick  = r_retry_tick;
        n_retry_fine  = r_retry_fine;
        n_grace_start = r_grace_start;
        n_last_rec    = r_last_rec;
        n_grace       = r_grace;
        n_attempts    = r_attempts;
        n_out         = '0;
        w_el_entry    = w_now - r_off_entry;
        w_el_grace    = w_now - r_grace_start;
        w_el_retry    = '0;
        w_el_fine     = '0;
        w_el_rec      = '0;
        w_due         = 1'b0;

        unique case (r_in_op)
            OP_UPDATE: begin
                if (r_cnt_pres) begin
                    if (r_in.tx_error_count > r_peak_tx) n_peak_tx = r_in.tx_error_count;
                    if (r_in.rx_error_count > r_peak_rx) n_peak_rx = r_in.rx_error_count;
                end
                if (r_in.bus_state != r_state) begin
                    n_out.state_changed = 1'b1;
                    n_state = r_in.bus_state;
                    unique case (r_in.bus_state)
                        BUS_OFF: begin
                            n_off_cnt    = r_off_cnt + 32'd1;
                            n_off_entry  = w_now;
                            n_retry_tick = w_now;
                            n_retry_fine = w_fnow;
                            if (!r_grace) n_attempts = '0;
                        end
                        BUS_WARNING: n_warn_cnt = r_warn_cnt + 32'd1;
                        BUS_PASSIVE: n_pass_cnt = r_pass_cnt + 32'd1;
                        default: begin
                            // leaving bus-off straight to active counts as a recovery
                            if (r_state == BUS_OFF) begin
                                n_off_sum  = r_off_sum + 32'(64'(w_el_entry));
                                n_last_rec = w_now;
                                n_grace    = 1'b0;
                            end
                        end
                    endcase
                end
                if (r_in.bus_state == BUS_OFF) begin
                    w_el_retry = w_now - n_retry_tick;
                    w_el_fine  = w_fnow - n_retry_fine;
                    w_due = r_use_fine ? (64'(w_el_fine) >= 64'(r_fine_delay))
                                       : (64'(w_el_retry) >= 64'(r_base_delay));
                    if (n_grace) begin
                        if (64'(w_el_grace) >= 64'(r_stable_run)) begin
                            n_grace      = 1'b0;
                            n_retry_tick = w_now;
                            n_retry_fine = w_fnow;
                            n_attempts   = 8'd1;
                            n_out.request_recovery = 1'b1;
                        end
                    end else if (r_auto_on && w_due) begin
                        if (r_att_limit == '0 || n_attempts < r_att_limit) begin
                            if (n_attempts != ATTEMPT_MAX) n_attempts = n_attempts + 8'd1;
                            n_out.request_recovery = 1'b1;
                            n_retry_tick = w_now;
                            n_retry_fine = w_fnow;
                        end else begin
                            n_out.recovery_failed = 1'b1;
                            n_grace       = 1'b1;
                            n_grace_start = w_now;
                        end
                    end
                end
                // stable active run clears the attempt series
                if (r_in.bus_state == BUS_ACTIVE && n_attempts != '0) begin
                    w_el_rec = w_now - n_last_rec;
                    if (64'(w_el_rec) >= 64'(r_stable_run)) n_attempts = '0;
                end
            end
            OP_TRIGGER: begin
                if (r_state != BUS_OFF) begin
                    n_out.status = 1'b1;
                end else begin
                    n_grace      = 1'b0;
                    n_retry_tick = w_now;
                    n_retry_fine = w_fnow;
                    n_attempts   = 8'd1;
                    n_out.request_recovery = 1'b1;
                end
            end
            OP_CLEAR_STATS: begin
                n_peak_tx  = r_cnt_pres ? r_in.tx_error_count : 8'd0;
                n_peak_rx  = r_cnt_pres ? r_in.rx_error_count : 8'd0;
                n_off_cnt  = '0;
                n_warn_cnt = '0;
                n_pass_cnt = '0;
                n_off_sum  = '0;
            end
            default: ;
        endcase

        n_out.held_state         = n_state;
        n_out.attempt_count      = n_attempts;
        n_out.peak_tx_errors     = n_peak_tx;
        n_out.peak_rx_errors     = n_peak_rx;
        n_out.bus_off_entries    = n_off_cnt;
        n_out.warning_entries    = n_warn_cnt;
        n_out.passive_entries    = n_pass_cnt;
        n_out.bus_off_total_time = n_off_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BUS_ACTIVE;
            r_peak_tx     <= '0;
            r_peak_rx     <= '0;
            r_off_cnt     <= '0;
            r_warn_cnt    <= '0;
            r_pass_cnt    <= '0;
            r_off_sum     <= '0;
            r_off_entry   <= '0;
            r_retry_tick  <= '0;
            r_retry_fine  <= '0;
            r_grace_start <= '0;
            r_last_rec    <= '0;
            r_grace       <= 1'b0;
            r_attempts    <= '0;
        end else if (w_advance) begin
            r_state       <= n_state;
            r_peak_tx     <= n_peak_tx;
            r_peak_rx     <= n_peak_rx;
            r_off_cnt     <= n_off_cnt;
            r_warn_cnt    <= n_warn_cnt;
            r_pass_cnt    <= n_pass_cnt;
            r_off_sum     <= n_off_sum;
            r_off_entry   <= n_off_entry;
            r_retry_tick  <= n_retry_tick;
            r_retry_fine  <= n_retry_fine;
            r_grace_start <= n_grace_start;
            r_last_rec    <= n_last_rec;
            r_grace       <= n_grace;
            r_attempts    <= n_attempts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) r_out <= n_out;
    end

`ifndef SYNTH
    // a processed item always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_vld)
        else $error("processed item did not reach the result register");

    // a refused trigger never asks for recovery
    a_refuse_no_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.status && r_out.request_recovery))
        else $error("refused trigger with recovery request");

    // the grace period only starts while in bus-off and without a request
    a_fail_in_bus_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.recovery_failed) |->
            (r_out.held_state == BUS_OFF && !r_out.request_recovery && r_grace))
        else $error("recovery failure outside bus-off");

    // monitor state holds while the master side stalls
    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !m_axis_tready) |=> $stable(r_state) && $stable(r_attempts))
        else $error("monitor state moved during output stall");
`endif

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the can bus-off recovery monitor: directed table, then random transfers
`timescale 1ns / 1ps

module tb;
    import cbrm_pkg::*;

    // the fourth op code has no name in the package, the block only reports on it
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PER_SETTING = 32;
    localparam int unsigned SAT_ITEMS   = 270;
    localparam int unsigned PLAN_LEN    = 6;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned SETTLE_GAP  = 4;

    // one full set of register values
    typedef struct packed {
        logic        use_fine;
        logic [31:0] base_delay;
        logic [31:0] fine_delay;
        logic [31:0] stable_run;
        logic        auto_on;
        logic [7:0]  att_limit;
        logic        cnt_pres;
    } t_settings;

    // one row of the directed table
    typedef struct packed {
        logic       reconfig;   // load the directed settings before this row
        logic       typed;      // exp was worked out by hand
        logic [1:0] op;
        t_in_item   item;
        t_out_item  exp;
    } t_row;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic [1:0]                s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [ADDR_BITS-1:0]      paddr         = '0;
    logic [31:0]               pwdata        = '0;
    logic [31:0]               prdata;
    logic                      pready;

    can_bus_off_recovery_monitor_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // register shadow, follows every write made to the block
    t_settings cfg = '0;

    // monitor state as the block should hold it, all zero after reset
    logic [1:0]  mon_state         = BUS_ACTIVE;
    logic [7:0]  mon_peak_tx       = '0;
    logic [7:0]  mon_peak_rx       = '0;
    logic [31:0] mon_off_cnt       = '0;
    logic [31:0] mon_warn_cnt      = '0;
    logic [31:0] mon_passive_cnt   = '0;
    logic [31:0] mon_off_sum       = '0;
    logic [31:0] mon_off_entry     = '0;
    logic [31:0] mon_retry_base    = '0;
    logic [31:0] mon_retry_fine    = '0;
    logic [31:0] mon_grace_start   = '0;
    logic [31:0] mon_last_recovery = '0;
    logic        mon_grace         = 1'b0;
    logic [7:0]  mon_attempts      = '0;

    // reports predicted for accepted transfers, oldest first
    t_out_item   awaited_reports [$];
    t_row        dir_rows [$];
    t_settings   plan [0:PLAN_LEN-1];
    t_settings   drill_cfg;

    int unsigned snd_idle_pct = 32;
    int unsigned rcv_idle_pct = 62;
    int unsigned mismatches   = 0;
    int unsigned reports_seen = 0;
    int unsigned stall_cycles = 0;

    // random walk that keeps the stream well formed
    logic [31:0] walk_base  = '0;
    logic [31:0] walk_fine  = '0;
    logic [1:0]  walk_state = BUS_ACTIVE;

    t_out_item   seen_rep;
    t_out_item   want_rep;

    // tick distance, wraps at 32 bits
    function automatic logic [31:0] since(input logic [31:0] now, input logic [31:0] mark);
        return now - mark;
    endfunction

    // one step of the monitor: updates the state above and returns the report
    function automatic t_out_item monitor_report(input logic [1:0] op, input t_in_item it);
        t_out_item  rep;
        logic [1:0] prev;
        logic       due;
        rep = '0;
        case (op)
            OP_UPDATE: begin
                prev = mon_state;
                if (cfg.cnt_pres) begin
                    if (it.tx_error_count > mon_peak_tx) mon_peak_tx = it.tx_error_count;
                    if (it.rx_error_count > mon_peak_rx) mon_peak_rx = it.rx_error_count;
                end
                if (it.bus_state != prev) begin
                    rep.state_changed = 1'b1;
                    mon_state = it.bus_state;
                    case (it.bus_state)
                        BUS_OFF: begin
                            mon_off_cnt    = mon_off_cnt + 32'd1;
                            mon_off_entry  = it.base_tick;
                            mon_retry_base = it.base_tick;
                            mon_retry_fine = it.fine_tick;
                            // a series survives re-entry while the grace period runs
                            if (!mon_grace) mon_attempts = 8'd0;
                        end
                        BUS_WARNING: mon_warn_cnt = mon_warn_cnt + 32'd1;
                        BUS_PASSIVE: mon_passive_cnt = mon_passive_cnt + 32'd1;
                        default: begin
                            // back to active: a recovery out of bus-off closes the off time
                            if (prev == BUS_OFF) begin
                                mon_off_sum = mon_off_sum + since(it.base_tick, mon_off_entry);
                                mon_last_recovery = it.base_tick;
                                mon_grace = 1'b0;
                            end
                        end
                    endcase
                end
                if (it.bus_state == BUS_OFF) begin
                    if (mon_grace) begin
                        if (since(it.base_tick, mon_grace_start) >= cfg.stable_run) begin
                            mon_grace      = 1'b0;
                            mon_retry_base = it.base_tick;
                            mon_retry_fine = it.fine_tick;
                            mon_attempts   = 8'd1;
                            rep.request_recovery = 1'b1;
                        end
                    end else if (cfg.auto_on) begin
                        due = cfg.use_fine ?
                              (since(it.fine_tick, mon_retry_fine) >= cfg.fine_delay) :
                              (since(it.base_tick, mon_retry_base) >= cfg.base_delay);
                        if (due) begin
                            if (cfg.att_limit == 8'd0 || mon_attempts < cfg.att_limit) begin
                                if (mon_attempts != ATTEMPT_MAX)
                                    mon_attempts = mon_attempts + 8'd1;
                                rep.request_recovery = 1'b1;
                                mon_retry_base = it.base_tick;
                                mon_retry_fine = it.fine_tick;
                            end else begin
                                rep.recovery_failed = 1'b1;
                                mon_grace       = 1'b1;
                                mon_grace_start = it.base_tick;
                            end
                        end
                    end
                end
                // a long enough active run ends the attempt series
                if (it.bus_state == BUS_ACTIVE && mon_attempts != 8'd0 &&
                    since(it.base_tick, mon_last_recovery) >= cfg.stable_run)
                    mon_attempts = 8'd0;
            end
            OP_TRIGGER: begin
                if (mon_state != BUS_OFF) begin
                    rep.status = 1'b1;
                end else begin
                    mon_grace      = 1'b0;
                    mon_retry_base = it.base_tick;
                    mon_retry_fine = it.fine_tick;
                    mon_attempts   = 8'd1;
                    rep.request_recovery = 1'b1;
                end
            end
            OP_CLEAR_STATS: begin
                mon_peak_tx     = cfg.cnt_pres ? it.tx_error_count : 8'd0;
                mon_peak_rx     = cfg.cnt_pres ? it.rx_error_count : 8'd0;
                mon_off_cnt     = '0;
                mon_warn_cnt    = '0;
                mon_passive_cnt = '0;
                mon_off_sum     = '0;
            end
            default: ;  // unused code only reports
        endcase
        rep.held_state         = mon_state;
        rep.attempt_count      = mon_attempts;
        rep.peak_tx_errors     = mon_peak_tx;
        rep.peak_rx_errors     = mon_peak_rx;
        rep.bus_off_entries    = mon_off_cnt;
        rep.warning_entries    = mon_warn_cnt;
        rep.passive_entries    = mon_passive_cnt;
        rep.bus_off_total_time = mon_off_sum;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("report %0d %s: expected %0h, actual %0h",
                         reports_seen, name, want, got);
        end
    endtask

    // apb write, back to back when called again, the caller releases the bus
    task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
    endtask

    // stop sending and wait until every report is back and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic apply_settings(input t_settings s);
        settle();
        reg_write(REG_USE_FINE,   32'(s.use_fine));
        reg_write(REG_BASE_DELAY, s.base_delay);
        reg_write(REG_FINE_DELAY, s.fine_delay);
        reg_write(REG_STABLE_RUN, s.stable_run);
        reg_write(REG_AUTO_ON,    32'(s.auto_on));
        reg_write(REG_ATT_LIMIT,  32'(s.att_limit));
        reg_write(REG_CNT_PRES,   32'(s.cnt_pres));
        psel    <= 1'b0;
        penable <= 1'b0;
        cfg = s;
    endtask

    // one input transfer; tvalid stays high unless the sender takes a gap
    task automatic send_item(input logic [1:0] op, input t_in_item it,
                             input logic typed, input t_out_item hand_rep);
        t_out_item rep;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_BITS'(it);
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!(s_axis_tvalid && s_axis_tready));
        rep = monitor_report(op, it);
        awaited_reports.push_back(typed ? hand_rep : rep);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic rc, input logic typed, input logic [1:0] op,
                           input logic [1:0] bs, input logic [7:0] tec, input logic [7:0] rec,
                           input logic [31:0] base, input logic [31:0] fine,
                           input t_out_item exp);
        t_row row;
        row.reconfig            = rc;
        row.typed               = typed;
        row.op                  = op;
        row.item.bus_state      = bs;
        row.item.tx_error_count = tec;
        row.item.rx_error_count = rec;
        row.item.base_tick      = base;
        row.item.fine_tick      = fine;
        row.exp                 = exp;
        dir_rows.push_back(row);
    endtask

    // mostly a sticky walk through the bus states with slowly rising ticks,
    // one item in ten is plain noise over every field
    task automatic next_random(input logic sat_run, output logic [1:0] op,
                               output t_in_item it);
        int unsigned pick;
        pick = $urandom_range(99);
        walk_base = walk_base + $urandom_range(6);
        walk_fine = walk_fine + $urandom_range(20);
        if ($urandom_range(99) >= 75) walk_state = 2'($urandom_range(3));
        it.bus_state      = sat_run ? BUS_OFF : walk_state;
        // small counts most of the time so peaks keep moving
        it.tx_error_count = 8'($urandom_range(255) >> $urandom_range(7));
        it.rx_error_count = 8'($urandom_range(255) >> $urandom_range(7));
        it.base_tick      = walk_base;
        it.fine_tick      = walk_fine;
        op = OP_UPDATE;
        if (!sat_run) begin
            if (pick < 10) begin
                op                = 2'($urandom);
                it.bus_state      = 2'($urandom);
                it.tx_error_count = 8'($urandom);
                it.rx_error_count = 8'($urandom);
                it.base_tick      = $urandom;
                it.fine_tick      = $urandom;
            end else if (pick < 18) begin
                op = OP_TRIGGER;
            end else if (pick < 23) begin
                op = OP_CLEAR_STATS;
            end else if (pick < 27) begin
                op = OP_UNUSED;
            end
        end
    endtask

    // result side: check every report transfer, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            reports_seen++;
            seen_rep = m_axis_tdata[$bits(t_out_item)-1:0];
            if (awaited_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("report %0d arrived with none expected: %h",
                             reports_seen, m_axis_tdata);
            end else begin
                want_rep = awaited_reports.pop_front();
                check_field("status", 32'(want_rep.status), 32'(seen_rep.status));
                check_field("held_state", 32'(want_rep.held_state),
                            32'(seen_rep.held_state));
                check_field("state_changed", 32'(want_rep.state_changed),
                            32'(seen_rep.state_changed));
                check_field("request_recovery", 32'(want_rep.request_recovery),
                            32'(seen_rep.request_recovery));
                check_field("attempt_count", 32'(want_rep.attempt_count),
                            32'(seen_rep.attempt_count));
                check_field("recovery_failed", 32'(want_rep.recovery_failed),
                            32'(seen_rep.recovery_failed));
                check_field("peak_tx_errors", 32'(want_rep.peak_tx_errors),
                            32'(seen_rep.peak_tx_errors));
                check_field("peak_rx_errors", 32'(want_rep.peak_rx_errors),
                            32'(seen_rep.peak_rx_errors));
                check_field("bus_off_entries", want_rep.bus_off_entries,
                            seen_rep.bus_off_entries);
                check_field("warning_entries", want_rep.warning_entries,
                            seen_rep.warning_entries);
                check_field("passive_entries", want_rep.passive_entries,
                            seen_rep.passive_entries);
                check_field("bus_off_total_time", want_rep.bus_off_total_time,
                            seen_rep.bus_off_total_time);
                check_field("zero fill", 32'd0,
                            32'(m_axis_tdata[OUT_TDATA_BITS-1:$bits(t_out_item)]));
            end
        end
        m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // watchdog: too long without any transfer on either stream or the config port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_out_item  zero_rep;
        t_out_item  refused_rep;
        logic [1:0] op;
        t_in_item   it;
        zero_rep    = '0;
        refused_rep = '0;
        refused_rep.status = 1'b1;

        // short limits so requests, failures and grace exits all show up
        drill_cfg = '{1'b0, 32'd2, 32'hFFFF_FFFF, 32'd3, 1'b1, 8'd1, 1'b1};

        // settings for the random part: each register sees both extremes
        plan[0] = '{1'b0, 32'd5, 32'hFFFF_FFFF, 32'd10, 1'b1, 8'd3, 1'b1};
        plan[1] = '{1'b1, 32'hFFFF_FFFF, 32'd4, 32'd0, 1'b1, 8'd1, 1'b0};
        plan[2] = '{1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 8'd255, 1'b1};
        plan[3] = '{1'b1, 32'd0, 32'd9, 32'd6, 1'b0, 8'd2, 1'b1};
        plan[4] = '{1'b0, 32'd3, 32'd7, 32'd20, 1'b1, 8'd0, 1'b1};
        // long bus-off stay with no limit and no delay: attempts saturate
        plan[5] = '{1'b0, 32'd0, 32'd0, 32'd5, 1'b1, 8'd0, 1'b1};

        // reset settings: counters absent, no auto recovery
        // rc typed  op              state        tec    rec    base          fine
        add_row(0, 1, OP_UPDATE,      BUS_ACTIVE,  8'hFF, 8'hFF, 32'd0,        32'd0,
                zero_rep);
        // trigger outside bus-off is refused
        add_row(0, 1, OP_TRIGGER,     BUS_ACTIVE,  8'h00, 8'h00, 32'd0,        32'd0,
                refused_rep);
        // unused op code only reports
        add_row(0, 1, OP_UNUSED,      BUS_OFF,     8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_WARNING, 8'd17, 8'd3,  32'd10,       32'd40,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_PASSIVE, 8'd130, 8'd140, 32'd20,     32'd90,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'hFF, 8'h00, 32'd100,      32'd200,
                zero_rep);
        add_row(0, 0, OP_TRIGGER,     BUS_OFF,     8'h00, 8'h00, 32'd150,      32'd260,
                zero_rep);
        // statistics reset with counters absent keeps peaks at zero
        add_row(0, 0, OP_CLEAR_STATS, BUS_OFF,     8'hAA, 8'h55, 32'd160,      32'd270,
                zero_rep);
        // recovery at the top of the tick range
        add_row(0, 0, OP_UPDATE,      BUS_ACTIVE,  8'h00, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                zero_rep);
        // directed settings from here on
        add_row(1, 0, OP_UPDATE,      BUS_ACTIVE,  8'hFF, 8'h00, 32'd2,        32'd5,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'd12, 8'hFF, 32'hFFFF_FFFE, 32'd10,
                zero_rep);
        // delay over: first request
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'h00, 8'h00, 32'd1,        32'd11,
                zero_rep);
        // limit reached: grace period starts
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'h00, 8'h00, 32'd4,        32'd12,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'h00, 8'h00, 32'd6,        32'd13,
                zero_rep);
        // grace period over: retry
        add_row(0, 0, OP_UPDATE,      BUS_OFF,     8'h00, 8'h00, 32'd7,        32'd14,
                zero_rep);
        add_row(0, 0, OP_UPDATE,      BUS_ACTIVE,  8'h00, 8'h00, 32'd8,        32'd15,
                zero_rep);
        // stable run clears the series
        add_row(0, 0, OP_UPDATE,      BUS_ACTIVE,  8'h00, 8'h00, 32'd11,       32'd16,
                zero_rep);
        // statistics reset loads peaks from the inputs
        add_row(0, 0, OP_CLEAR_STATS, BUS_ACTIVE,  8'd3,  8'd200, 32'd12,      32'd20,
                zero_rep);
        add_row(0, 0, OP_TRIGGER,     BUS_WARNING, 8'h00, 8'h00, 32'd13,       32'd21,
                zero_rep);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].reconfig) apply_settings(drill_cfg);
            send_item(dir_rows[n].op, dir_rows[n].item, dir_rows[n].typed, dir_rows[n].exp);
        end

        for (int s = 0; s < PLAN_LEN; s++) begin
            // receiver-heavy idling, then sender-heavy, then none
            snd_idle_pct = (s < 2) ? 32 : (s < 4) ? 62 : 0;
            rcv_idle_pct = (s < 2) ? 62 : (s < 4) ? 32 : 0;
            apply_settings(plan[s]);
            // start some settings right below the tick wrap
            walk_base = ($urandom_range(1) != 0) ? 32'hFFFF_FFC0 : $urandom;
            walk_fine = $urandom;
            for (int k = 0; k < ((s == PLAN_LEN - 1) ? SAT_ITEMS : PER_SETTING); k++) begin
                next_random(s == PLAN_LEN - 1, op, it);
                send_item(op, it, 1'b0, zero_rep);
            end
        end

        settle();
        if (mismatches == 0 && awaited_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cbrm_pkg.sv
hw/rtl/can_bus_off_recovery_monitor_top.sv
bench/tb.sv
